[src/lcd4_pkg.sv]
// Shared types, constants and lookup functions for the 4-bit character LCD sequencer.
`timescale 1ns / 1ps

package lcd4_pkg;

  localparam int unsigned REG_W  = 20;
  localparam int unsigned HOLD_W = 21;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CMD_W  = 3;

  typedef enum logic [1:0] {
    ACT_CMD  = 2'd0,
    ACT_DATA = 2'd1,
    ACT_GOTO = 2'd2,
    ACT_INIT = 2'd3
  } action_t;

  // register indexes on the write port
  localparam logic [IDX_W-1:0] REG_PHASE_HOLD    = 3'd0;
  localparam logic [IDX_W-1:0] REG_POWER_UP_HOLD = 3'd1;
  localparam logic [IDX_W-1:0] REG_CLEAR_EXTRA   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ENTRY_EXTRA   = 3'd3;
  localparam logic [IDX_W-1:0] REG_GOTO_EXTRA    = 3'd4;

  localparam logic [REG_W-1:0] PHASE_HOLD_RST    = 20'd1000;
  localparam logic [REG_W-1:0] POWER_UP_HOLD_RST = 20'd1000;
  localparam logic [REG_W-1:0] CLEAR_EXTRA_RST   = 20'd20000;
  localparam logic [REG_W-1:0] ENTRY_EXTRA_RST   = 20'd10000;
  localparam logic [REG_W-1:0] GOTO_EXTRA_RST    = 20'd100000;

  // positions in the init command list that carry an extra wait
  localparam logic [CMD_W-1:0] INIT_CLEAR_POS = 3'd4;
  localparam logic [CMD_W-1:0] INIT_ENTRY_POS = 3'd5;
  localparam logic [CMD_W-1:0] INIT_LAST_POS  = 3'd5;

  localparam logic [1:0] PHASE_LAST = 2'd3;

  typedef struct packed {
    logic             load;     // item accepted this cycle
    logic             emit;     // produce one result beat
    logic             wait_ph;  // power-up wait beat
    logic             init;     // item is the init sequence
    logic [1:0]       phase;    // hi/en, hi, lo/en, lo
    logic [CMD_W-1:0] cmd;      // init command position
    logic             last;     // final beat of the item
  } ctl_t;

  function automatic logic [7:0] init_cmd(input logic [CMD_W-1:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h33;
      3'd1:    c = 8'h32;
      3'd2:    c = 8'h28;
      3'd3:    c = 8'h0E;
      3'd4:    c = 8'h01;
      3'd5:    c = 8'h06;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    unique case (row)
      2'd0: b = 8'h80;
      2'd1: b = 8'hC0;
      2'd2: b = 8'h94;
      2'd3: b = 8'hD4;
    endcase
    return b;
  endfunction

endpackage

[src/lcd4_ctrl.sv]
// Sequencer state machine: walks the wait beat, init commands and nibble phases.
`timescale 1ns / 1ps

module lcd4_ctrl
  import lcd4_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] action,
  output logic       busy,
  output ctl_t       ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_BYTE
  } state_t;

  state_t           state;
  logic [1:0]       phase;
  logic [CMD_W-1:0] cmd;
  logic             init;

  logic load;
  logic last;

  assign load = start && (state == S_IDLE);
  assign last = (state == S_BYTE) && (phase == PHASE_LAST) &&
                (!init || (cmd == INIT_LAST_POS));
  assign busy = (state != S_IDLE);

  assign ctl.load    = load;
  assign ctl.emit    = (state != S_IDLE);
  assign ctl.wait_ph = (state == S_WAIT);
  assign ctl.init    = init;
  assign ctl.phase   = phase;
  assign ctl.cmd     = cmd;
  assign ctl.last    = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= '0;
      cmd   <= '0;
      init  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            phase <= '0;
            cmd   <= '0;
            init  <= (action == ACT_INIT);
            state <= (action == ACT_INIT) ? S_WAIT : S_BYTE;
          end
        end
        S_WAIT: begin
          state <= S_BYTE;
        end
        S_BYTE: begin
          phase <= phase + 2'd1;
          if (phase == PHASE_LAST) begin
            if (last) state <= S_IDLE;
            else      cmd   <= cmd + 3'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/lcd4_dp.sv]
// Datapath: config registers, item latch, pin-state and hold computation, result registers.
`timescale 1ns / 1ps

module lcd4_dp
  import lcd4_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  input  logic [1:0]        action,
  input  logic [7:0]        byte_value,
  input  logic [1:0]        row_index,
  input  logic [5:0]        column_index,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [REG_W-1:0]  wr_data,
  output logic              strobe,
  output logic              reg_select,
  output logic              enable_pin,
  output logic [3:0]        data_nibble,
  output logic [HOLD_W-1:0] hold_units,
  output logic              last_phase
);

  logic [REG_W-1:0] phase_hold;
  logic [REG_W-1:0] power_up_hold;
  logic [REG_W-1:0] clear_extra;
  logic [REG_W-1:0] entry_extra;
  logic [REG_W-1:0] goto_extra;

  logic       item_rs;
  logic       item_goto;
  logic [7:0] item_byte;

  logic [7:0]       byte_cur;
  logic [REG_W-1:0] extra;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_hold    <= PHASE_HOLD_RST;
      power_up_hold <= POWER_UP_HOLD_RST;
      clear_extra   <= CLEAR_EXTRA_RST;
      entry_extra   <= ENTRY_EXTRA_RST;
      goto_extra    <= GOTO_EXTRA_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PHASE_HOLD:    phase_hold    <= wr_data;
        REG_POWER_UP_HOLD: power_up_hold <= wr_data;
        REG_CLEAR_EXTRA:   clear_extra   <= wr_data;
        REG_ENTRY_EXTRA:   entry_extra   <= wr_data;
        REG_GOTO_EXTRA:    goto_extra    <= wr_data;
        default: ;
      endcase
    end
  end

  // cursor address wraps to 8 bits
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_rs   <= (action == ACT_DATA);
      item_goto <= (action == ACT_GOTO);
      item_byte <= (action == ACT_GOTO) ? row_base(row_index) + {2'b00, column_index}
                                        : byte_value;
    end
  end

  assign byte_cur = ctl.init ? init_cmd(ctl.cmd) : item_byte;

  always_comb begin
    extra = '0;
    if (ctl.phase == PHASE_LAST) begin
      if (ctl.init) begin
        if (ctl.cmd == INIT_CLEAR_POS) extra = clear_extra;
        if (ctl.cmd == INIT_ENTRY_POS) extra = entry_extra;
      end else if (item_goto) begin
        extra = goto_extra;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= ctl.emit;
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      last_phase <= ctl.last;
      if (ctl.wait_ph) begin
        reg_select  <= 1'b0;
        enable_pin  <= 1'b0;
        data_nibble <= '0;
        hold_units  <= {1'b0, power_up_hold};
      end else begin
        reg_select  <= ctl.init ? 1'b0 : item_rs;
        enable_pin  <= ~ctl.phase[0];
        data_nibble <= ctl.phase[1] ? byte_cur[3:0] : byte_cur[7:4];
        hold_units  <= {1'b0, phase_hold} + {1'b0, extra};
      end
    end
  end

endmodule

[src/char_lcd_4bit_write_sequencer_top.sv]
// Top level of the 4-bit character LCD write sequencer.
//
// Usage: raise start with action and its operand fields; the item is taken
// at a clock edge where start is high and busy is low. Each pin state
// comes out as one beat: strobe is high for exactly one cycle with
// reg_select, read_write, enable_pin, data_nibble, hold_units and
// last_phase valid; last_phase marks the final beat of the item.
// The first beat is registered in the datapath after the sequencer leaves
// idle, then one beat per cycle. Command, data and cursor items give four
// beats; an init item gives 25 (one power-up wait, six commands).
// Busy drops while the final beat is on the ports, so a new item is taken
// only after the previous one has finished its last nibble phase.
// Registers are to be written through wr_en/wr_index/wr_data only while
// idle; the block itself does not enforce this. Unknown indexes are
// dropped. Synchronous rst returns the registers to their defaults and
// the sequencer to idle, with no beat pending.
// Beats cannot be held off: the receiver must take each one as it comes.
`timescale 1ns / 1ps

module char_lcd_4bit_write_sequencer_top
  import lcd4_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        action,
  input  logic [7:0]        byte_value,
  input  logic [1:0]        row_index,
  input  logic [5:0]        column_index,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [REG_W-1:0]  wr_data,
  output logic              strobe,
  output logic              reg_select,
  output logic              read_write,
  output logic              enable_pin,
  output logic [3:0]        data_nibble,
  output logic [HOLD_W-1:0] hold_units,
  output logic              last_phase
);

  ctl_t ctl;

  assign read_write = 1'b0;

  lcd4_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .busy   (busy),
    .ctl    (ctl)
  );

  lcd4_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .action       (action),
    .byte_value   (byte_value),
    .row_index    (row_index),
    .column_index (column_index),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .strobe       (strobe),
    .reg_select   (reg_select),
    .enable_pin   (enable_pin),
    .data_nibble  (data_nibble),
    .hold_units   (hold_units),
    .last_phase   (last_phase)
  );

endmodule

[src/lcd4_chk.sv]
// Port-level checker for the LCD sequencer, bound to the top level.
`timescale 1ns / 1ps

module lcd4_chk (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic       reg_select,
  input logic       enable_pin,
  input logic [3:0] data_nibble,
  input logic       last_phase
);

  // accepted item keeps the block busy and starts a beat stream
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !strobe))
    else $error("accept not followed by busy");

  // an item's beats come back to back until the last one
  a_contig: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_phase) |=> strobe)
    else $error("gap inside a beat stream");

  // every enable-high phase is followed by enable low on the same nibble
  a_en_pair: assert property (@(posedge clk) disable iff (rst)
    (strobe && enable_pin) |=>
      (strobe && !enable_pin && data_nibble == $past(data_nibble) &&
       reg_select == $past(reg_select)))
    else $error("enable pulse not closed");

  // the final beat leaves enable low, and busy has dropped by then
  a_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_phase) |-> (!enable_pin && !busy))
    else $error("bad final beat");

endmodule

bind char_lcd_4bit_write_sequencer_top lcd4_chk u_lcd4_chk (.*);
